// ----- rtl/fqmm_pkg.sv -----
// Shared types, constants and helpers for the FIFO queue with min/max scan.
package fqmm_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam int CQ_AW = 1;
  localparam int CQ_DEPTH = 1 << CQ_AW;

  localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W - 1){1'b0}}};

  localparam logic [2:0] REQ_PUSH  = 3'd0;
  localparam logic [2:0] REQ_POP   = 3'd1;
  localparam logic [2:0] REQ_CLEAR = 3'd2;
  localparam logic [2:0] REQ_LIST  = 3'd3;
  localparam logic [2:0] REQ_MIN   = 3'd4;
  localparam logic [2:0] REQ_MAX   = 3'd5;
  localparam logic [2:0] REQ_EVENS = 3'd6;

  typedef enum logic [2:0] {
    OP_PUSH, OP_POP, OP_CLEAR, OP_LIST, OP_MIN, OP_MAX, OP_EVENS, OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_POP, BK_RD, BK_USE, BK_DONE
  } back_state_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  value;
    logic                      last;
  } res_t;

  // Ring slot at offset b from a; b never exceeds DEPTH.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- rtl/fqmm_in_if.sv -----
// Request channel: valid/ready handshake with request type and push value.
interface fqmm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

// ----- rtl/fqmm_out_if.sv -----
// Result channel: valid/ready handshake with status, value and last flag.
interface fqmm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] result_value;
  logic               last;

  modport source (output valid, output status, output result_value, output last,
                  input ready);
  modport sink   (input valid, input status, input result_value, input last,
                  output ready);
endinterface

// ----- rtl/fqmm_front.sv -----
// Front end: decodes requests into commands and buffers them in a small queue.
module fqmm_front (
  input  logic               clk,
  input  logic               rst_n,
  fqmm_in_if.sink            in_if,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output fqmm_pkg::cmd_t     cmd
);

  fqmm_pkg::cmd_t                    q_r [fqmm_pkg::CQ_DEPTH];
  logic [fqmm_pkg::CQ_AW-1:0]        wptr_r, wptr_nxt;
  logic [fqmm_pkg::CQ_AW-1:0]        rptr_r, rptr_nxt;
  logic [fqmm_pkg::CQ_AW:0]          cnt_r, cnt_nxt;
  logic                              push_en, pop_en;
  fqmm_pkg::cmd_t                    dec_cmd;

  always_comb begin
    dec_cmd.value = in_if.push_value;
    case (in_if.req_type)
      fqmm_pkg::REQ_PUSH:  dec_cmd.op = fqmm_pkg::OP_PUSH;
      fqmm_pkg::REQ_POP:   dec_cmd.op = fqmm_pkg::OP_POP;
      fqmm_pkg::REQ_CLEAR: dec_cmd.op = fqmm_pkg::OP_CLEAR;
      fqmm_pkg::REQ_LIST:  dec_cmd.op = fqmm_pkg::OP_LIST;
      fqmm_pkg::REQ_MIN:   dec_cmd.op = fqmm_pkg::OP_MIN;
      fqmm_pkg::REQ_MAX:   dec_cmd.op = fqmm_pkg::OP_MAX;
      fqmm_pkg::REQ_EVENS: dec_cmd.op = fqmm_pkg::OP_EVENS;
      default:             dec_cmd.op = fqmm_pkg::OP_NOP;
    endcase
  end

  assign in_if.ready = (cnt_r != (fqmm_pkg::CQ_AW + 1)'(fqmm_pkg::CQ_DEPTH));
  assign cmd_valid   = (cnt_r != '0);
  assign cmd         = q_r[rptr_r];

  assign push_en = in_if.valid && in_if.ready;
  assign pop_en  = cmd_valid && cmd_ready;

  always_comb begin
    wptr_nxt = push_en ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop_en ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push_en && !pop_en) begin
      cnt_nxt = cnt_r + (fqmm_pkg::CQ_AW + 1)'(1);
    end else if (pop_en && !push_en) begin
      cnt_nxt = cnt_r - (fqmm_pkg::CQ_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      q_r[wptr_r] <= dec_cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (fqmm_pkg::CQ_AW + 1)'(fqmm_pkg::CQ_DEPTH))
    else $error("command queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == (fqmm_pkg::CQ_AW + 1)'(fqmm_pkg::CQ_DEPTH))
      |-> (wptr_r == rptr_r))
    else $error("command queue pointers disagree with count");

endmodule

// ----- rtl/fqmm_back.sv -----
// Back end: ring storage, head/count state, request execution and result register.
module fqmm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  fqmm_pkg::cmd_t     cmd,
  fqmm_out_if.source         out_if
);

  localparam int IDX_W = fqmm_pkg::IDX_W;
  localparam int CNT_W = fqmm_pkg::CNT_W;
  localparam int DATA_W = fqmm_pkg::DATA_W;

  fqmm_pkg::back_state_t     state_r, state_nxt;
  fqmm_pkg::op_t             op_r, op_nxt;
  logic [IDX_W-1:0]          head_r, head_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic signed [DATA_W-1:0]  best_r, best_nxt;
  logic signed [DATA_W-1:0]  pend_r, pend_nxt;
  logic                      pend_valid_r, pend_valid_nxt;
  fqmm_pkg::res_t            res_r, res_nxt;

  logic [DATA_W-1:0]         ring_mem [fqmm_pkg::DEPTH];
  logic signed [DATA_W-1:0]  rd_data_r;
  logic                      mem_we, mem_re;
  logic [IDX_W-1:0]          mem_waddr, mem_raddr;

  logic                      out_valid_r;
  fqmm_pkg::res_t            out_res_r;
  logic                      can_load, out_load;
  fqmm_pkg::res_t            out_load_res;

  logic                      is_last, is_even, better;
  logic signed [DATA_W-1:0]  best_upd;

  assign can_load = !out_valid_r || out_if.ready;

  assign is_last = (idx_r == count_r - CNT_W'(1));
  assign is_even = !rd_data_r[0];
  assign better  = (idx_r == '0) ||
                   ((op_r == fqmm_pkg::OP_MIN) ? (rd_data_r < best_r) : (rd_data_r > best_r));
  assign best_upd = better ? rd_data_r : best_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    best_nxt       = best_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    res_nxt        = res_r;
    cmd_ready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = fqmm_pkg::wrap_add(head_r, count_r);
    mem_re         = 1'b0;
    mem_raddr      = fqmm_pkg::wrap_add(head_r, idx_r);
    out_load       = 1'b0;
    out_load_res   = res_r;

    case (state_r)
      fqmm_pkg::BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          op_nxt         = cmd.op;
          idx_nxt        = '0;
          pend_valid_nxt = 1'b0;
          res_nxt        = '{status: fqmm_pkg::ST_OK, value: '0, last: 1'b1};
          state_nxt      = fqmm_pkg::BK_DONE;
          case (cmd.op)
            fqmm_pkg::OP_PUSH: begin
              if (count_r >= CNT_W'(fqmm_pkg::DEPTH)) begin
                res_nxt.status = fqmm_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            fqmm_pkg::OP_POP: begin
              if (count_r == '0) begin
                res_nxt.status = fqmm_pkg::ST_EMPTY;
                res_nxt.value  = fqmm_pkg::MOST_NEG;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = fqmm_pkg::BK_POP;
              end
            end
            fqmm_pkg::OP_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
            end
            fqmm_pkg::OP_LIST, fqmm_pkg::OP_MIN, fqmm_pkg::OP_MAX,
            fqmm_pkg::OP_EVENS: begin
              if (count_r == '0) begin
                res_nxt.status = fqmm_pkg::ST_EMPTY;
              end else begin
                state_nxt = fqmm_pkg::BK_RD;
              end
            end
            default: ;
          endcase
        end
      end

      fqmm_pkg::BK_POP: begin
        res_nxt.value = rd_data_r;
        head_nxt      = fqmm_pkg::wrap_add(head_r, CNT_W'(1));
        count_nxt     = count_r - CNT_W'(1);
        state_nxt     = fqmm_pkg::BK_DONE;
      end

      fqmm_pkg::BK_RD: begin
        mem_re    = 1'b1;
        state_nxt = fqmm_pkg::BK_USE;
      end

      fqmm_pkg::BK_USE: begin
        case (op_r)
          fqmm_pkg::OP_LIST: begin
            if (can_load) begin
              out_load     = 1'b1;
              out_load_res = '{status: fqmm_pkg::ST_OK, value: rd_data_r, last: is_last};
              idx_nxt      = idx_r + CNT_W'(1);
              state_nxt    = is_last ? fqmm_pkg::BK_IDLE : fqmm_pkg::BK_RD;
            end
          end
          fqmm_pkg::OP_MIN, fqmm_pkg::OP_MAX: begin
            best_nxt = best_upd;
            idx_nxt  = idx_r + CNT_W'(1);
            if (is_last) begin
              res_nxt   = '{status: fqmm_pkg::ST_OK, value: best_upd, last: 1'b1};
              state_nxt = fqmm_pkg::BK_DONE;
            end else begin
              state_nxt = fqmm_pkg::BK_RD;
            end
          end
          default: begin
            // Evens: hold one found value back so the final one can carry last.
            if (!(is_even && pend_valid_r && !can_load)) begin
              if (is_even) begin
                if (pend_valid_r) begin
                  out_load     = 1'b1;
                  out_load_res = '{status: fqmm_pkg::ST_OK, value: pend_r, last: 1'b0};
                end
                pend_nxt       = rd_data_r;
                pend_valid_nxt = 1'b1;
              end
              idx_nxt = idx_r + CNT_W'(1);
              if (is_last) begin
                if (is_even || pend_valid_r) begin
                  res_nxt = '{status: fqmm_pkg::ST_OK,
                              value: is_even ? rd_data_r : pend_r, last: 1'b1};
                end else begin
                  res_nxt = '{status: fqmm_pkg::ST_EMPTY, value: '0, last: 1'b1};
                end
                state_nxt = fqmm_pkg::BK_DONE;
              end else begin
                state_nxt = fqmm_pkg::BK_RD;
              end
            end
          end
        endcase
      end

      fqmm_pkg::BK_DONE: begin
        if (can_load) begin
          out_load     = 1'b1;
          out_load_res = res_r;
          state_nxt    = fqmm_pkg::BK_IDLE;
        end
      end

      default: state_nxt = fqmm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fqmm_pkg::BK_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
    pend_r <= pend_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_res_r <= out_load_res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= cmd.value;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[mem_raddr];
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_res_r.status;
  assign out_if.result_value = out_res_r.value;
  assign out_if.last         = out_res_r.last;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(fqmm_pkg::DEPTH))
    else $error("entry count exceeds ring depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> can_load)
    else $error("result register overwritten while held");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fqmm_pkg::BK_IDLE && cmd_valid && cmd.op == fqmm_pkg::OP_CLEAR)
      |=> (count_r == '0 && head_r == '0))
    else $error("clear did not reset head and count");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fqmm_pkg::BK_RD || state_r == fqmm_pkg::BK_USE) |-> (idx_r < count_r))
    else $error("scan index past entry count");

endmodule

// ----- rtl/fifo_queue_with_min_max_scan_core.sv -----
// Top level of the FIFO queue with min/max scan: request front end and execution back end.
//
//  channel  | dir | handshake      | payload
//  in_if    | in  | valid/ready    | req_type[2:0], push_value[31:0] signed
//  out_if   | out | valid/ready    | status[1:0], result_value[31:0] signed, last
//
//  Push, clear, unknown, any scan of an empty queue: idle, then done; pop: idle, pop, done, for the ring read.
//  List: one registered ring read per entry, a read state then a use state that loads the item.
//  Minimum, maximum, evens: a read state then a use state per entry; a done state loads the final item.
//  A two-entry command queue takes requests while the back end is busy.
//  Synchronous active-low reset empties the queue and sets head and count to zero.
//  A stalled result holds the back end; the front keeps accepting until its queue fills.
module fifo_queue_with_min_max_scan_core (
  input  logic        clk,
  input  logic        rst_n,
  fqmm_in_if.sink     in_if,
  fqmm_out_if.source  out_if
);

  logic            cmd_valid;
  logic            cmd_ready;
  fqmm_pkg::cmd_t  cmd;

  fqmm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  fqmm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_if    (out_if)
  );

endmodule

// ----- sim/fifo_queue_with_min_max_scan_core_tb.sv -----
// Testbench for the FIFO queue with min/max scan: random requests checked against a queue model.
`timescale 1ns / 1ps

module fifo_queue_with_min_max_scan_core_tb;

  localparam int          TOTAL_ITEMS  = 320;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 80;    // longer than a full 32-entry scan

  // Tracks the queue contents and the results each request should produce.
  class queue_scoreboard;
    logic [fqmm_pkg::DATA_W-1:0] ring [fqmm_pkg::DEPTH];
    int unsigned                 head;
    int unsigned                 count;
    fqmm_pkg::res_t              expected_results[$];
    int unsigned                 failures;

    function new();
      head     = 0;
      count    = 0;
      failures = 0;
    endfunction

    function void queue_result(fqmm_pkg::status_t st, logic [fqmm_pkg::DATA_W-1:0] v,
                               logic lst);
      fqmm_pkg::res_t r;
      r.status = st;
      r.value  = v;
      r.last   = lst;
      expected_results.push_back(r);
    endfunction

    function void note_request(fqmm_pkg::op_t op, logic [fqmm_pkg::DATA_W-1:0] v);
      logic [fqmm_pkg::DATA_W-1:0] best;
      int unsigned                 found;
      int unsigned                 slot;
      int unsigned                 i;
      found = 0;
      case (op)
        fqmm_pkg::OP_PUSH: begin
          if (count >= fqmm_pkg::DEPTH) begin
            queue_result(fqmm_pkg::ST_FULL, '0, 1'b1);
          end else begin
            ring[(head + count) % fqmm_pkg::DEPTH] = v;
            count++;
            queue_result(fqmm_pkg::ST_OK, '0, 1'b1);
          end
        end
        fqmm_pkg::OP_POP: begin
          if (count == 0) begin
            queue_result(fqmm_pkg::ST_EMPTY, fqmm_pkg::MOST_NEG, 1'b1);
          end else begin
            queue_result(fqmm_pkg::ST_OK, ring[head], 1'b1);
            head = (head + 1) % fqmm_pkg::DEPTH;
            count--;
          end
        end
        fqmm_pkg::OP_CLEAR: begin
          head  = 0;
          count = 0;
          queue_result(fqmm_pkg::ST_OK, '0, 1'b1);
        end
        fqmm_pkg::OP_LIST: begin
          if (count == 0) begin
            queue_result(fqmm_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < count; i++) begin
              queue_result(fqmm_pkg::ST_OK, ring[(head + i) % fqmm_pkg::DEPTH],
                           (i + 1 == count));
            end
          end
        end
        fqmm_pkg::OP_MIN, fqmm_pkg::OP_MAX: begin
          if (count == 0) begin
            queue_result(fqmm_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            best = ring[head];
            for (i = 1; i < count; i++) begin
              slot = (head + i) % fqmm_pkg::DEPTH;
              if (op == fqmm_pkg::OP_MIN ? ($signed(ring[slot]) < $signed(best))
                                         : ($signed(ring[slot]) > $signed(best))) begin
                best = ring[slot];
              end
            end
            queue_result(fqmm_pkg::ST_OK, best, 1'b1);
          end
        end
        fqmm_pkg::OP_EVENS: begin
          for (i = 0; i < count; i++) begin
            slot = (head + i) % fqmm_pkg::DEPTH;
            if (!ring[slot][0]) begin
              queue_result(fqmm_pkg::ST_OK, ring[slot], 1'b0);
              found++;
            end
          end
          if (found == 0) begin
            queue_result(fqmm_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            expected_results[expected_results.size() - 1].last = 1'b1;
          end
        end
        default: begin
          queue_result(fqmm_pkg::ST_OK, '0, 1'b1);
        end
      endcase
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) begin
        $display("[%0t] %s", $realtime, msg);
      end
    endfunction

    function void check_result(logic [1:0] st, logic [fqmm_pkg::DATA_W-1:0] v, logic lst);
      fqmm_pkg::res_t want;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d value %h last %0d", st, v, lst));
      end else begin
        want = expected_results.pop_front();
        if (st !== want.status || v !== want.value || lst !== want.last) begin
          note_failure($sformatf(
            "mismatch: status exp %0d got %0d, value exp %h got %h, last exp %0d got %0d",
            want.status, st, want.value, v, want.last, lst));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fqmm_in_if  in_if ();
  fqmm_out_if out_if ();

  fifo_queue_with_min_max_scan_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  queue_scoreboard queue_check = new();

  bit          steady       = 1'b0;   // both sides stop idling
  bit          hold_request = 1'b0;   // asks the result side for a long stall
  int          items_sent   = 0;
  int unsigned cycle_count  = 0;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: checks accepted items and stalls at random.
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        queue_check.check_result(out_if.status, out_if.result_value, out_if.last);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Valid stays high from one item to the next unless a gap is inserted.
  task automatic send_request(input fqmm_pkg::op_t op,
                              input logic [fqmm_pkg::DATA_W-1:0] v);
    steady = (items_sent >= 130) && (items_sent < 210);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.req_type   <= op;
    in_if.push_value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    queue_check.note_request(op, v);
    items_sent++;
  endtask

  function automatic logic [fqmm_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return fqmm_pkg::MOST_NEG;
      2:       return '0;
      3:       return '1;
      4:       return fqmm_pkg::DATA_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic fqmm_pkg::op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return fqmm_pkg::OP_PUSH;
    if (r < 62) return fqmm_pkg::OP_POP;
    if (r < 70) return fqmm_pkg::OP_LIST;
    if (r < 78) return fqmm_pkg::OP_MIN;
    if (r < 86) return fqmm_pkg::OP_MAX;
    if (r < 94) return fqmm_pkg::OP_EVENS;
    if (r < 97) return fqmm_pkg::OP_CLEAR;
    return fqmm_pkg::OP_NOP;
  endfunction

  initial begin : request_source
    bit hold_done;
    hold_done        = 1'b0;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.req_type   = fqmm_pkg::OP_NOP;
    in_if.push_value = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue on pop and on every scan request type
    send_request(fqmm_pkg::OP_POP, $urandom);
    send_request(fqmm_pkg::OP_LIST, $urandom);
    send_request(fqmm_pkg::OP_MIN, $urandom);
    send_request(fqmm_pkg::OP_MAX, $urandom);
    send_request(fqmm_pkg::OP_EVENS, $urandom);
    // extremes, then every scan over them
    send_request(fqmm_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_request(fqmm_pkg::OP_PUSH, fqmm_pkg::MOST_NEG);
    send_request(fqmm_pkg::OP_PUSH, 32'h0000_0000);
    send_request(fqmm_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_request(fqmm_pkg::OP_PUSH, 32'h0000_0001);
    send_request(fqmm_pkg::OP_PUSH, 32'hFFFF_FFFE);
    send_request(fqmm_pkg::OP_LIST, $urandom);
    send_request(fqmm_pkg::OP_MIN, $urandom);
    send_request(fqmm_pkg::OP_MAX, $urandom);
    send_request(fqmm_pkg::OP_EVENS, $urandom);
    send_request(fqmm_pkg::OP_NOP, $urandom);
    send_request(fqmm_pkg::OP_POP, $urandom);
    send_request(fqmm_pkg::OP_POP, $urandom);
    send_request(fqmm_pkg::OP_CLEAR, $urandom);
    // only odd entries: evens finds nothing
    send_request(fqmm_pkg::OP_PUSH, 32'h0000_0003);
    send_request(fqmm_pkg::OP_PUSH, 32'hFFFF_FFFB);
    send_request(fqmm_pkg::OP_EVENS, $urandom);
    send_request(fqmm_pkg::OP_LIST, $urandom);
    send_request(fqmm_pkg::OP_CLEAR, $urandom);

    while (items_sent < TOTAL_ITEMS) begin
      if (!hold_done && items_sent >= 60) begin
        hold_done    = 1'b1;
        hold_request = 1'b1;
      end
      case ($urandom_range(0, 3))
        0: begin
          // fill to the top, push past it, then scan the full ring
          while (queue_check.count < fqmm_pkg::DEPTH) begin
            send_request(fqmm_pkg::OP_PUSH, pick_value());
          end
          repeat ($urandom_range(1, 2)) send_request(fqmm_pkg::OP_PUSH, pick_value());
          send_request(fqmm_pkg::op_t'($urandom_range(fqmm_pkg::OP_LIST, fqmm_pkg::OP_EVENS)),
                       $urandom);
        end
        1: begin
          repeat ($urandom_range(1, queue_check.count + 1)) begin
            send_request(fqmm_pkg::OP_POP, $urandom);
          end
        end
        default: begin
          repeat (12) send_request(pick_op(), pick_value());
        end
      endcase
    end
    in_if.valid <= 1'b0;
    steady = 1'b0;

    while (queue_check.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (queue_check.failures == 0 && queue_check.expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fqmm_pkg.sv
rtl/fqmm_in_if.sv
rtl/fqmm_out_if.sv
rtl/fqmm_front.sv
rtl/fqmm_back.sv
rtl/fifo_queue_with_min_max_scan_core.sv
sim/fifo_queue_with_min_max_scan_core_tb.sv
